[design/buddy_block_allocator_top_macros.svh]
// Assertion macros for the buddy block allocator.
// Needs a clock and reset in scope at the point of use.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BBA_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define BBA_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

[design/bba_pkg.sv]
// Package for the buddy block allocator: mark codes, status codes, states.
// No dependencies.
`default_nettype none
package bba_pkg;
   typedef enum logic [1:0] {
      MARK_ABSENT = 2'd0,
      MARK_FREE   = 2'd1,
      MARK_ALLOC  = 2'd2,
      MARK_SPLIT  = 2'd3
   } mark_type;
   localparam logic [1:0] STATUS_GRANTED = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_FREED   = 2'd2;
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_A_RD, ST_A_EVAL, ST_A_UP, ST_A_UPRD, ST_A_UPEVAL,
      ST_F_RD, ST_F_EVAL, ST_M_RD, ST_M_EVAL, ST_DONE
   } state_type;
endpackage
`default_nettype wire

[design/buddy_block_allocator_top.sv]
// Buddy block allocator, single module over a node mark memory.
// Uses bba_pkg and buddy_block_allocator_top_macros.svh.
//
// Usage: a request transaction (req_mode, req_block_order, req_block_start)
// is taken on req_valid and req_ready. One response transaction
// (rsp_status, rsp_granted_start) follows on rsp_valid/rsp_ready.
// The node marks live in a memory with one access per cycle, so every node
// visited passes through a read state and an evaluate state. An allocation
// walks down the tree depth first: a free node that is halved first writes
// its two children as free, a node already split descends to its left child
// directly, and each step back up when it backtracks goes through ST_A_UP.
// A free walks down by start address, reading and evaluating each node, and
// then merges upward one level at a time while the buddy is free. The
// request is accepted in ST_IDLE and the response presented in ST_DONE.
// One request is in the block at a time; req_ready is low while it works
// and while the response waits. A stalled receiver holds the response.
// After reset a clearing pass writes every node, one per cycle, before the
// first request is taken.
`default_nettype none
`include "buddy_block_allocator_top_macros.svh"
module buddy_block_allocator_top #(
   parameter int MEMORY_UNITS = 1024,
   parameter int MIN_BLOCK = 1
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_mode,
   input  wire logic [3:0] req_block_order,
   input  wire logic [9:0] req_block_start,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_status,
   output logic [9:0]      rsp_granted_start
);
   localparam int NODES = 2 * MEMORY_UNITS - 1;
   localparam int IW = $clog2(NODES + 1);
   localparam int SW = $clog2(MEMORY_UNITS + 1);
   localparam logic [IW-1:0] LAST = IW'(NODES - 1);

   logic [1:0] mem [NODES];
   logic [1:0] rd_ff;
   logic [IW-1:0] addr;
   logic we;
   logic [1:0] wd;

   bba_pkg::state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [SW-1:0] size_ff, size_in, start_ff, start_in;
   logic [SW-1:0] req_ff, req_in, where_ff;
   logic [1:0] st_ff, st_in;
   logic [9:0] gs_ff, gs_in;
   logic [1:0] left_ff, left_in;
   logic came_left_ff, came_left_in;
   logic [SW-1:0] half;
   logic [IW-1:0] lc, rc, par;
   logic [16:0] req_full;

   assign half = size_ff >> 1;
   assign lc = IW'({idx_ff, 1'b1});
   assign rc = IW'({idx_ff, 1'b0} + 2);
   assign par = (idx_ff - IW'(1)) >> 1;
   assign req_full = 17'(1) << req_block_order;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wd;
      end
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::ST_CLEAR;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
      size_ff <= size_in;
      start_ff <= start_in;
      req_ff <= req_in;
      st_ff <= st_in;
      gs_ff <= gs_in;
      left_ff <= left_in;
      came_left_ff <= came_left_in;
      if (req_valid && req_ready) begin
         where_ff <= SW'(req_block_start);
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      size_in = size_ff;
      start_in = start_ff;
      req_in = req_ff;
      st_in = st_ff;
      gs_in = gs_ff;
      left_in = left_ff;
      came_left_in = came_left_ff;
      addr = idx_ff;
      we = 1'b0;
      wd = bba_pkg::MARK_ABSENT;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         bba_pkg::ST_CLEAR: begin
            we = 1'b1;
            wd = (idx_ff == '0) ? bba_pkg::MARK_FREE : bba_pkg::MARK_ABSENT;
            if (idx_ff == LAST) begin
               idx_in = '0;
               state_in = bba_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         bba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            idx_in = '0;
            size_in = SW'(MEMORY_UNITS);
            start_in = '0;
            st_in = bba_pkg::STATUS_FREED;
            gs_in = '0;
            if (req_full > 17'(MEMORY_UNITS)) begin
               req_in = '0;
            end else begin
               req_in = SW'(req_full);
            end
            if (req_valid) begin
               if (req_mode) begin
                  state_in = (req_full > 17'(MEMORY_UNITS)) ? bba_pkg::ST_DONE
                                                            : bba_pkg::ST_F_RD;
               end else if (req_full > 17'(MEMORY_UNITS)) begin
                  st_in = bba_pkg::STATUS_REFUSED;
                  state_in = bba_pkg::ST_DONE;
               end else begin
                  state_in = bba_pkg::ST_A_RD;
               end
            end
         end
         bba_pkg::ST_A_RD: begin
            state_in = bba_pkg::ST_A_EVAL;
         end
         bba_pkg::ST_A_EVAL: begin
            if (rd_ff == bba_pkg::MARK_ABSENT || rd_ff == bba_pkg::MARK_ALLOC
                || size_ff < req_ff) begin
               state_in = bba_pkg::ST_A_UP;
            end else if (rd_ff == bba_pkg::MARK_FREE && !(half >= req_ff
                         && half >= SW'(MIN_BLOCK) && size_ff > SW'(1))) begin
               we = 1'b1;
               wd = bba_pkg::MARK_ALLOC;
               st_in = bba_pkg::STATUS_GRANTED;
               gs_in = 10'(start_ff);
               state_in = bba_pkg::ST_DONE;
            end else begin
               if (rd_ff == bba_pkg::MARK_FREE) begin
                  we = 1'b1;
                  wd = bba_pkg::MARK_SPLIT;
                  left_in = 2'd2;
               end else begin
                  left_in = 2'd0;
               end
               state_in = bba_pkg::ST_A_UPRD;
            end
         end
         bba_pkg::ST_A_UPRD: begin
            // Writes children of a freshly split node, if any, then descends left.
            if (left_ff == 2'd2) begin
               addr = rc;
               we = 1'b1;
               wd = bba_pkg::MARK_FREE;
               left_in = 2'd1;
            end else begin
               if (left_ff == 2'd1) begin
                  addr = lc;
                  we = 1'b1;
                  wd = bba_pkg::MARK_FREE;
               end
               idx_in = lc;
               size_in = half;
               state_in = bba_pkg::ST_A_RD;
            end
         end
         bba_pkg::ST_A_UP: begin
            if (idx_ff == '0) begin
               st_in = bba_pkg::STATUS_REFUSED;
               state_in = bba_pkg::ST_DONE;
            end else if (idx_ff[0]) begin
               idx_in = idx_ff + IW'(1);
               start_in = start_ff + size_ff;
               state_in = bba_pkg::ST_A_RD;
            end else begin
               idx_in = par;
               size_in = size_ff << 1;
               start_in = start_ff - size_ff;
            end
         end
         bba_pkg::ST_F_RD: begin
            state_in = bba_pkg::ST_F_EVAL;
         end
         bba_pkg::ST_F_EVAL: begin
            if (rd_ff == bba_pkg::MARK_ABSENT) begin
               state_in = bba_pkg::ST_DONE;
            end else if (start_ff == where_ff && size_ff == req_ff) begin
               if (rd_ff == bba_pkg::MARK_ALLOC) begin
                  we = 1'b1;
                  wd = bba_pkg::MARK_FREE;
                  state_in = (idx_ff == '0) ? bba_pkg::ST_DONE : bba_pkg::ST_M_RD;
                  came_left_in = idx_ff[0];
               end else begin
                  state_in = bba_pkg::ST_DONE;
               end
            end else if (rd_ff != bba_pkg::MARK_SPLIT) begin
               state_in = bba_pkg::ST_DONE;
            end else begin
               size_in = half;
               if (where_ff < start_ff + half) begin
                  idx_in = lc;
               end else begin
                  idx_in = rc;
                  start_in = start_ff + half;
               end
               state_in = bba_pkg::ST_F_RD;
            end
         end
         bba_pkg::ST_M_RD: begin
            // Reads the buddy of the node just freed.
            addr = came_left_ff ? idx_ff + IW'(1) : idx_ff - IW'(1);
            state_in = bba_pkg::ST_M_EVAL;
         end
         bba_pkg::ST_M_EVAL: begin
            if (rd_ff != bba_pkg::MARK_FREE) begin
               state_in = bba_pkg::ST_DONE;
            end else if (left_ff == 2'd0) begin
               addr = idx_ff;
               we = 1'b1;
               left_in = 2'd1;
            end else if (left_ff == 2'd1) begin
               addr = came_left_ff ? idx_ff + IW'(1) : idx_ff - IW'(1);
               we = 1'b1;
               left_in = 2'd2;
            end else begin
               addr = par;
               we = 1'b1;
               wd = bba_pkg::MARK_FREE;
               left_in = 2'd0;
               idx_in = par;
               came_left_in = par[0];
               state_in = (par == '0) ? bba_pkg::ST_DONE : bba_pkg::ST_M_RD;
            end
         end
         bba_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
      if (state_ff == bba_pkg::ST_F_EVAL) begin
         left_in = 2'd0;
      end
   end

   assign rsp_status = st_ff;
   assign rsp_granted_start = gs_ff;

   `BBA_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == bba_pkg::ST_IDLE)
   `BBA_ASSERT_IMP(a_no_overlap, clock, reset, req_ready, !rsp_valid)
   `BBA_ASSERT_IMP(a_refused_zero, clock, reset,
      rsp_valid && rsp_status != bba_pkg::STATUS_GRANTED, rsp_granted_start == '0)
   `BBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench for the buddy block allocator: directed and random allocate and
// free transactions, checked against a predictor of the node mark tree.
// Depends on bba_pkg and buddy_block_allocator_top.
`timescale 1ns / 1ps
`default_nettype none

class alloc_scoreboard;
   localparam int UNITS = 1024;
   localparam int NODES = 2 * UNITS - 1;
   bba_pkg::mark_type marks[NODES];
   logic [1:0] status_q[$];
   logic [9:0] start_q[$];
   int errors;

   function void clear_tree();
      for (int i = 0; i < NODES; i++) marks[i] = bba_pkg::MARK_ABSENT;
      marks[0] = bba_pkg::MARK_FREE;
      errors = 0;
   endfunction

   function bit search(int idx, int size, int base, int need, ref int at);
      int half;
      if (idx >= NODES) return 0;
      if (marks[idx] == bba_pkg::MARK_ABSENT || marks[idx] == bba_pkg::MARK_ALLOC
          || size < need) return 0;
      half = size >> 1;
      if (marks[idx] == bba_pkg::MARK_FREE) begin
         if (half >= need && half >= 1 && 2 * idx + 2 < NODES) begin
            marks[idx] = bba_pkg::MARK_SPLIT;
            marks[2 * idx + 1] = bba_pkg::MARK_FREE;
            marks[2 * idx + 2] = bba_pkg::MARK_FREE;
         end else begin
            marks[idx] = bba_pkg::MARK_ALLOC;
            at = base;
            return 1;
         end
      end
      if (search(2 * idx + 1, half, base, need, at)) return 1;
      return search(2 * idx + 2, half, base + half, need, at);
   endfunction

   function void release_node(int need, int where);
      int idx, size, base, half, par;
      idx = 0; size = UNITS; base = 0;
      forever begin
         if (idx >= NODES || marks[idx] == bba_pkg::MARK_ABSENT) return;
         if (base == where && size == need) break;
         if (marks[idx] != bba_pkg::MARK_SPLIT) return;
         half = size >> 1;
         if (where < base + half) idx = 2 * idx + 1;
         else begin
            idx = 2 * idx + 2;
            base += half;
         end
         size = half;
      end
      if (marks[idx] != bba_pkg::MARK_ALLOC) return;
      marks[idx] = bba_pkg::MARK_FREE;
      while (idx > 0) begin
         par = (idx - 1) >> 1;
         if (marks[2 * par + 1] != bba_pkg::MARK_FREE ||
             marks[2 * par + 2] != bba_pkg::MARK_FREE) break;
         marks[2 * par + 1] = bba_pkg::MARK_ABSENT;
         marks[2 * par + 2] = bba_pkg::MARK_ABSENT;
         marks[par] = bba_pkg::MARK_FREE;
         idx = par;
      end
   endfunction

   function void note_request(bit mode, logic [3:0] order, logic [9:0] where);
      int at;
      at = 0;
      if (!mode) begin
         if (search(0, UNITS, 0, 1 << order, at)) begin
            status_q.push_back(bba_pkg::STATUS_GRANTED);
            start_q.push_back(at[9:0]);
         end else begin
            status_q.push_back(bba_pkg::STATUS_REFUSED);
            start_q.push_back('0);
         end
      end else begin
         release_node(1 << order, where);
         status_q.push_back(bba_pkg::STATUS_FREED);
         start_q.push_back('0);
      end
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_response(logic [1:0] status, logic [9:0] start);
      logic [1:0] es;
      logic [9:0] eg;
      if (status_q.size() == 0) begin
         report("response with none outstanding");
         return;
      end
      es = status_q.pop_front();
      eg = start_q.pop_front();
      if (status !== es) report($sformatf("status %0d, wanted %0d", status, es));
      if (start !== eg) report($sformatf("start %0d, wanted %0d", start, eg));
   endtask
endclass

module tb;
   logic clock = 0, reset = 1;
   logic req_valid = 0, req_mode = 0, rsp_ready = 0;
   logic [3:0] req_block_order = 0;
   logic [9:0] req_block_start = 0;
   logic req_ready, rsp_valid;
   logic [1:0] rsp_status;
   logic [9:0] rsp_granted_start;
   alloc_scoreboard board;
   int idle_cycles;
   logic [9:0] granted[$];
   logic [3:0] granted_order[$];
   logic [3:0] last_order;

   buddy_block_allocator_top DUT (.*);

   always #10 clock = ~clock;

   function int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (req_valid && req_ready) begin
            board.note_request(req_mode, req_block_order, req_block_start);
            last_order = req_block_order;
         end
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_status, rsp_granted_start);
            if (rsp_status == bba_pkg::STATUS_GRANTED) begin
               granted.push_back(rsp_granted_start);
               granted_order.push_back(last_order);
            end
         end
         if (idle_cycles > 50000) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   always begin
      @(negedge clock);
      if (!reset) begin
         if (rsp_ready && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 0;
            repeat (1 + gap_length()) @(negedge clock);
         end
         rsp_ready <= 1;
      end
   end

   task send(bit mode, logic [3:0] order, logic [9:0] where);
      req_valid <= 1;
      req_mode <= mode;
      req_block_order <= order;
      req_block_start <= where;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid <= 0;
      repeat (1 + gap_length()) @(negedge clock);
   endtask

   task free_random_grant();
      int k;
      if (granted.size() == 0) begin
         send(1, 4'($urandom_range(0, 10)), 10'($urandom));
         return;
      end
      k = $urandom_range(0, granted.size() - 1);
      send(1, granted_order[k], granted[k]);
      granted.delete(k);
      granted_order.delete(k);
   endtask

   initial begin
      int r;
      board = new();
      board.clear_tree();
      idle_cycles = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send(0, 10, 0);
      send(0, 0, 0);
      send(1, 10, 0);
      send(0, 0, 0);
      send(0, 15, 0);
      send(0, 11, 0);
      send(1, 0, 0);
      send(0, 9, 0);
      send(0, 9, 0);
      send(0, 9, 0);
      send(1, 9, 512);
      send(1, 9, 512);
      send(1, 9, 1023);
      send(1, 0, 1023);
      send(1, 9, 0);
      send(0, 0, 1023);
      send(0, 3, 10'h2AA);
      send(1, 3, 8);
      send(1, 0, 0);
      send(1, 15, 10'h155);
      while (board.status_q.size()) @(negedge clock);
      for (int n = 0; n < 450; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            send(0, 4'($urandom_range(0, 5) + ($urandom_range(0, 9) == 0 ? 5 : 0)),
                 10'($urandom));
         else if (r < 85) free_random_grant();
         else send(1'($urandom), 4'($urandom), 10'($urandom));
         if (n == 225) while (board.status_q.size()) @(negedge clock);
      end
      while (board.status_q.size()) @(negedge clock);
      repeat (100) @(negedge clock);
      if (board.errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
+incdir+design
design/bba_pkg.sv
design/buddy_block_allocator_top.sv
verif/tb.sv
